>>> rtl/core/pobk_pkg.sv
// Shared types, constants and wave functions of the polyphonic oscillator bank.
package pobk_pkg;

    localparam int VOICE_W  = 7;
    localparam int STEP_W   = 24;
    localparam int VEL_W    = 7;
    localparam int VOL_W    = 16;
    localparam int WAVE_W   = 16;
    localparam int SAMPLE_W = 32;
    localparam int CFG_IDX_W = 2;

    // floor(2^30 / 127): quotient estimate is exact or one low
    localparam logic [23:0] RECIP_127   = 24'd8454660;
    localparam int          RECIP_SHIFT = 30;
    localparam logic [6:0]  DIV_127     = 7'd127;

    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM = 2'd1;

    localparam logic [VOL_W-1:0] VOLUME_RESET = 16'd256;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_CHANGE = 2'd1,
        OP_STOP   = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        WF_SINE     = 2'd0,
        WF_TRIANGLE = 2'd1,
        WF_SAW      = 2'd2,
        WF_SQUARE   = 2'd3
    } t_wave;

    typedef struct packed {
        t_op                op;
        logic [VOICE_W-1:0] voice;
        logic [STEP_W-1:0]  step;
        logic [VEL_W-1:0]   vel;
        logic [STEP_W-1:0]  start;
    } t_cmd;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctl;

    typedef struct packed {
        logic                      vld;
        logic [VEL_W-1:0]          level;
        logic signed [WAVE_W-1:0]  wave;
    } t_mix_in;

    typedef struct packed {
        logic                        vld;
        logic                        busy;
        logic signed [SAMPLE_W-1:0]  value;
    } t_term;

    localparam logic [15:0] FRAC_QUARTER = 16'h4000;
    localparam logic [15:0] FRAC_3QUART  = 16'hC000;

    // round(32767 * sin(pi * i / 128)), i = 0..64
    localparam logic [14:0] QSINE [65] = '{
        15'd0,     15'd804,   15'd1608,  15'd2411,  15'd3212,  15'd4011,  15'd4808,  15'd5602,
        15'd6393,  15'd7179,  15'd7962,  15'd8739,  15'd9512,  15'd10278, 15'd11039, 15'd11793,
        15'd12539, 15'd13279, 15'd14010, 15'd14732, 15'd15446, 15'd16151, 15'd16846, 15'd17530,
        15'd18204, 15'd18868, 15'd19519, 15'd20159, 15'd20787, 15'd21403, 15'd22005, 15'd22594,
        15'd23170, 15'd23731, 15'd24279, 15'd24811, 15'd25329, 15'd25832, 15'd26319, 15'd26790,
        15'd27245, 15'd27683, 15'd28105, 15'd28510, 15'd28898, 15'd29268, 15'd29621, 15'd29956,
        15'd30273, 15'd30571, 15'd30852, 15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31971,
        15'd32137, 15'd32285, 15'd32412, 15'd32521, 15'd32609, 15'd32678, 15'd32728, 15'd32757,
        15'd32767
    };

    function automatic logic signed [15:0] clamp15(logic signed [17:0] v);
        logic signed [15:0] res;
        if (v > 18'sd32767) begin
            res = 16'sh7FFF;
        end else if (v < -18'sd32768) begin
            res = -16'sh8000;
        end else begin
            res = 16'(v);
        end
        return res;
    endfunction

    // Wave value in Q1.15 from a 16-bit phase fraction
    function automatic logic signed [15:0] wave_at(t_wave sel, logic [15:0] f);
        logic [6:0]         idx;
        logic signed [16:0] sv;
        logic signed [17:0] fs;
        logic signed [17:0] tv;
        logic signed [15:0] res;
        fs  = signed'({2'b00, f});
        idx = f[14] ? (7'd64 - {1'b0, f[13:8]}) : {1'b0, f[13:8]};
        sv  = signed'({2'b00, QSINE[idx]});
        tv  = '0;
        res = '0;
        unique case (sel)
            WF_SINE: begin
                res = f[15] ? 16'(-sv) : 16'(sv);
            end
            WF_TRIANGLE: begin
                if (f < FRAC_QUARTER) begin
                    tv = fs <<< 1;
                end else if (f < FRAC_3QUART) begin
                    tv = (18'sd32768 - fs) <<< 1;
                end else begin
                    tv = (fs - 18'sd65536) <<< 1;
                end
                res = clamp15(tv);
            end
            WF_SAW: begin
                tv  = 18'sd32768 - fs;
                res = clamp15(tv);
            end
            WF_SQUARE: begin
                res = f[15] ? -16'sh8000 : 16'sh7FFF;
            end
            default: begin
                res = '0;
            end
        endcase
        return res;
    endfunction

endpackage

>>> rtl/core/pobk_front.sv
// Input side: accept transfers, drop note events for absent voices, queue commands.
module pobk_front
    import pobk_pkg::*;
#(
    parameter int VOICES = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_op,
    input  logic [VOICE_W-1:0] i_voice,
    input  logic [STEP_W-1:0]  i_phase_step,
    input  logic [VEL_W-1:0]   i_velocity,
    input  logic [STEP_W-1:0]  i_start_phase,
    output t_cmd               o_cmd,
    output logic               o_cmd_vld,
    input  t_back_ctl          i_ctl
);

    localparam int FQ_DEPTH = 2;
    localparam int PTR_W    = $clog2(FQ_DEPTH);
    localparam int CNT_W    = $clog2(FQ_DEPTH + 1);

    t_cmd             r_fifo [FQ_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_count;

    t_op  in_op;
    logic accept;
    logic keep;
    logic push;
    logic pop;
    logic full;

    assign in_op  = t_op'(i_op);
    assign full   = (r_count == CNT_W'(FQ_DEPTH));
    assign o_in_stall = full || i_ctl.clearing;
    assign accept = i_in_valid && !o_in_stall;
    // ticks always go through; note events only for voices that exist
    assign keep   = (in_op == OP_TICK) || (32'(i_voice) < 32'(VOICES));
    assign push   = accept && keep;
    assign pop    = i_ctl.pop;

    assign o_cmd     = r_fifo[r_rp];
    assign o_cmd_vld = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wp] <= '{op: in_op, voice: i_voice, step: i_phase_step,
                              vel: i_velocity, start: i_start_phase};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> o_cmd_vld)
        else $error("command popped from empty queue");

    a_no_push_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clearing |-> !push)
        else $error("command queued during voice table clear");

endmodule

>>> rtl/core/pobk_mix.sv
// Per-voice gain pipeline: volume * velocity * wave / 127, truncated toward zero.
module pobk_mix
    import pobk_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [VOL_W-1:0] i_volume,
    input  t_mix_in          i_in,
    output t_term            o_term
);

    localparam int T_W  = VOL_W + VEL_W;      // volume * velocity
    localparam int P_W  = T_W + 24;           // times reciprocal
    localparam int QA_W = VOL_W;              // (volume * velocity) / 127
    localparam int Q2_W = 15;                 // (rem * |wave|) / 127

    logic [6:0] r_vld;

    // stage 1
    logic [T_W-1:0]    r_s1_t;
    logic              r_s1_neg;
    logic [WAVE_W-1:0] r_s1_wabs;
    // stage 2
    logic [P_W-1:0]    r_s2_p;
    logic [T_W-1:0]    r_s2_t;
    logic              r_s2_neg;
    logic [WAVE_W-1:0] r_s2_wabs;
    // stage 3
    logic [QA_W-1:0]   r_s3_qa;
    logic [VEL_W-1:0]  r_s3_ra;
    logic              r_s3_neg;
    logic [WAVE_W-1:0] r_s3_wabs;
    // stage 4
    logic [T_W-1:0]      r_s4_y;
    logic [SAMPLE_W-1:0] r_s4_m1;
    logic                r_s4_neg;
    // stage 5
    logic [P_W-1:0]      r_s5_p;
    logic [T_W-1:0]      r_s5_y;
    logic [SAMPLE_W-1:0] r_s5_m1;
    logic                r_s5_neg;
    // stage 6
    logic [Q2_W-1:0]     r_s6_q2;
    logic [SAMPLE_W-1:0] r_s6_m1;
    logic                r_s6_neg;
    // stage 7
    logic signed [SAMPLE_W-1:0] r_s7_term;

    logic [WAVE_W-1:0] in_wabs;
    logic [QA_W-1:0]   s3_q0;
    logic [T_W-1:0]    s3_rem;
    logic [Q2_W-1:0]   s6_q0;
    logic [T_W-1:0]    s6_rem;
    logic [SAMPLE_W-1:0] s7_mag;

    assign in_wabs = i_in.wave[WAVE_W-1] ? WAVE_W'(~i_in.wave + 1'b1) : WAVE_W'(i_in.wave);

    assign s3_q0  = r_s2_p[RECIP_SHIFT +: QA_W];
    assign s3_rem = r_s2_t - T_W'({7'b0, s3_q0} * {16'b0, DIV_127});

    assign s6_q0  = r_s5_p[RECIP_SHIFT +: Q2_W];
    assign s6_rem = r_s5_y - T_W'({8'b0, s6_q0} * {16'b0, DIV_127});

    assign s7_mag = r_s6_m1 + SAMPLE_W'(r_s6_q2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[5:0], i_in.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_t    <= T_W'({7'b0, i_volume} * {16'b0, i_in.level});
        r_s1_neg  <= i_in.wave[WAVE_W-1];
        r_s1_wabs <= in_wabs;

        r_s2_p    <= P_W'({24'b0, r_s1_t} * {23'b0, RECIP_127});
        r_s2_t    <= r_s1_t;
        r_s2_neg  <= r_s1_neg;
        r_s2_wabs <= r_s1_wabs;

        // estimate is exact or one low: one compare fixes it
        if (s3_rem >= T_W'(DIV_127)) begin
            r_s3_qa <= s3_q0 + 1'b1;
            r_s3_ra <= VEL_W'(s3_rem - T_W'(DIV_127));
        end else begin
            r_s3_qa <= s3_q0;
            r_s3_ra <= VEL_W'(s3_rem);
        end
        r_s3_neg  <= r_s2_neg;
        r_s3_wabs <= r_s2_wabs;

        r_s4_y   <= {16'b0, r_s3_ra} * {7'b0, r_s3_wabs};
        r_s4_m1  <= {16'b0, r_s3_qa} * {16'b0, r_s3_wabs};
        r_s4_neg <= r_s3_neg;

        r_s5_p   <= P_W'({24'b0, r_s4_y} * {23'b0, RECIP_127});
        r_s5_y   <= r_s4_y;
        r_s5_m1  <= r_s4_m1;
        r_s5_neg <= r_s4_neg;

        if (s6_rem >= T_W'(DIV_127)) begin
            r_s6_q2 <= s6_q0 + 1'b1;
        end else begin
            r_s6_q2 <= s6_q0;
        end
        r_s6_m1  <= r_s5_m1;
        r_s6_neg <= r_s5_neg;

        r_s7_term <= r_s6_neg ? -signed'(s7_mag) : signed'(s7_mag);
    end

    assign o_term.vld   = r_vld[6];
    assign o_term.busy  = |r_vld;
    assign o_term.value = r_s7_term;

endmodule

>>> rtl/core/pobk_back.sv
// Execution side: voice table, note updates, tick walk, accumulation and output register.
module pobk_back
    import pobk_pkg::*;
#(
    parameter int VOICES     = 128,
    parameter int PHASE_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic                 i_cmd_vld,
    output t_back_ctl            o_ctl,
    input  t_wave                i_waveform,
    output t_mix_in              o_mix_in,
    input  t_term                i_term,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [SAMPLE_W-1:0]  o_sample
);

    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int WORD_W = 1 + VEL_W + 2 * PHASE_BITS;
    localparam int ACC_W  = SAMPLE_W + $clog2(VOICES) + 1;
    localparam logic [VIDX_W-1:0] LAST_IDX = VIDX_W'(VOICES - 1);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_CHG_WR = 6'b000100,
        S_TICK   = 6'b001000,
        S_DRAIN  = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [VIDX_W-1:0]   r_idx, n_idx;
    t_cmd                r_cmd;
    logic                r_s1_vld;
    logic [VIDX_W-1:0]   r_s1_addr;
    logic [WORD_W-1:0]   r_mem [VOICES];
    logic [WORD_W-1:0]   r_rd_data;
    logic signed [ACC_W-1:0] r_acc;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_sample;

    logic                rd_en;
    logic [VIDX_W-1:0]   rd_addr;
    logic                wr_en;
    logic [VIDX_W-1:0]   wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic                pop;
    logic                acc_clr;
    logic                out_load;
    logic                out_free;

    logic                  rd_active;
    logic [VEL_W-1:0]      rd_level;
    logic [PHASE_BITS-1:0] rd_step;
    logic [PHASE_BITS-1:0] rd_phase;
    logic [15:0]           s1_frac;
    logic [ACC_W-SAMPLE_W:0] acc_hi;
    logic [SAMPLE_W-1:0]   sat;

    assign rd_active = r_rd_data[WORD_W-1];
    assign rd_level  = r_rd_data[WORD_W-2 -: VEL_W];
    assign rd_step   = r_rd_data[2*PHASE_BITS-1 -: PHASE_BITS];
    assign rd_phase  = r_rd_data[PHASE_BITS-1:0];

    generate
        if (PHASE_BITS >= 16) begin : g_frac_hi
            assign s1_frac = rd_phase[PHASE_BITS-1 -: 16];
        end else begin : g_frac_lo
            assign s1_frac = {rd_phase, {(16 - PHASE_BITS){1'b0}}};
        end
    endgenerate

    assign o_mix_in.vld   = r_s1_vld && rd_active;
    assign o_mix_in.level = rd_level;
    assign o_mix_in.wave  = wave_at(i_waveform, s1_frac);

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        rd_en    = 1'b0;
        rd_addr  = r_idx;
        wr_en    = 1'b0;
        wr_addr  = r_idx;
        wr_data  = '0;
        pop      = 1'b0;
        acc_clr  = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_cmd_vld) begin
                    pop     = 1'b1;
                    wr_addr = VIDX_W'(i_cmd.voice);
                    rd_addr = VIDX_W'(i_cmd.voice);
                    unique case (i_cmd.op)
                        OP_START: begin
                            wr_en   = 1'b1;
                            wr_data = {1'b1, i_cmd.vel, PHASE_BITS'(i_cmd.step),
                                       PHASE_BITS'(i_cmd.start)};
                        end
                        OP_CHANGE: begin
                            rd_en   = 1'b1;
                            n_state = S_CHG_WR;
                        end
                        OP_STOP: begin
                            wr_en = 1'b1;
                        end
                        OP_TICK: begin
                            acc_clr = 1'b1;
                            n_idx   = '0;
                            n_state = S_TICK;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CHG_WR: begin
                wr_addr = VIDX_W'(r_cmd.voice);
                wr_en   = rd_active;
                wr_data = {1'b1, r_cmd.vel, PHASE_BITS'(r_cmd.step), rd_phase};
                n_state = S_IDLE;
            end
            S_TICK: begin
                rd_en = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!r_s1_vld && !i_term.busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        // phase write-back of the voice whose entry was just read from the table
        if (r_s1_vld) begin
            wr_en   = rd_active;
            wr_addr = r_s1_addr;
            wr_data = {1'b1, rd_level, rd_step, rd_phase + rd_step};
        end
    end

    assign o_ctl.pop      = pop;
    assign o_ctl.clearing = (r_state == S_CLEAR);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // saturate the wide sum to 32 bits
    assign acc_hi = r_acc[ACC_W-1:SAMPLE_W-1];
    always_comb begin
        if ((&acc_hi) || !(|acc_hi)) begin
            sat = r_acc[SAMPLE_W-1:0];
        end else if (r_acc[ACC_W-1]) begin
            sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_cmd;
        end
        r_s1_addr <= r_idx;
        if (acc_clr) begin
            r_acc <= '0;
        end else if (i_term.vld) begin
            r_acc <= r_acc + ACC_W'($signed(i_term.value));
        end
        if (out_load) begin
            r_sample <= sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_s1_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_s1_vld <= (r_state == S_TICK);
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

    a_term_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_term.vld |-> (r_state == S_TICK || r_state == S_DRAIN))
        else $error("voice term arrived outside a tick");

    a_s1_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> (r_state == S_TICK || r_state == S_DRAIN))
        else $error("voice read in flight outside a tick");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished sample not moved to output register");

    a_out_no_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT || r_state == S_CLEAR) |-> !pop)
        else $error("command taken while sample pending or table clearing");

endmodule

>>> rtl/core/polyphonic_oscillator_bank_core.sv
// Top level of the polyphonic oscillator bank: config registers, front queue, engine, mixer.
// A note change reads the voice entry, then writes it back (read, then write); note start and stop write it directly.
// A tick walks all VOICES voice entries, one per cycle through one memory port, then drains
// the seven-stage gain pipeline before the finished sum goes to the output register.
// Ticks are taken one at a time; meanwhile the two-command input queue still takes transfers.
// After reset the whole voice table is cleared with o_in_stall high.
module polyphonic_oscillator_bank_core
    import pobk_pkg::*;
#(
    parameter int VOICES     = 128,
    parameter int PHASE_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VOL_W-1:0]     i_cfg_data,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_op,
    input  logic [VOICE_W-1:0]   i_voice,
    input  logic [STEP_W-1:0]    i_phase_step,
    input  logic [VEL_W-1:0]     i_velocity,
    input  logic [STEP_W-1:0]    i_start_phase,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [SAMPLE_W-1:0]  o_sample
);

    // Master volume (Q8.8) and wave select. The user must write them only while idle, so the
    // mixer may read them directly for the whole tick; the block itself does not enforce this.
    logic [VOL_W-1:0] r_volume;
    t_wave            r_waveform;

    // Front to back: head of the command queue and its valid, back to front:
    // pop and clear status.
    t_cmd      cmd;
    logic      cmd_vld;
    t_back_ctl ctl;

    // Engine to mixer and mixer back to engine.
    t_mix_in   mix_in;
    t_term     term;

    // Decode the register index; drop writes beyond the register list.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume   <= VOLUME_RESET;
            r_waveform <= WF_SINE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VOLUME: begin
                    r_volume <= i_cfg_data;
                end
                CFG_WAVEFORM: begin
                    r_waveform <= t_wave'(i_cfg_data[1:0]);
                end
                default: begin
                    r_volume <= r_volume;
                end
            endcase
        end
    end

    // Accept transfers, keep ticks and note events for existing voices.
    pobk_front #(
        .VOICES (VOICES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_voice       (i_voice),
        .i_phase_step  (i_phase_step),
        .i_velocity    (i_velocity),
        .i_start_phase (i_start_phase),
        .o_cmd         (cmd),
        .o_cmd_vld     (cmd_vld),
        .i_ctl         (ctl)
    );

    // Weight each active voice: volume * velocity * wave / 127, truncated.
    pobk_mix u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_volume (r_volume),
        .i_in     (mix_in),
        .o_term   (term)
    );

    // Run note updates and the tick walk; hold the finished sample in the
    // output register until its transfer.
    pobk_back #(
        .VOICES     (VOICES),
        .PHASE_BITS (PHASE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_vld   (cmd_vld),
        .o_ctl       (ctl),
        .i_waveform  (r_waveform),
        .o_mix_in    (mix_in),
        .i_term      (term),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sample    (o_sample)
    );

endmodule

>>> test/pobk_mix_checker.sv
// Checker for the oscillator bank: tracks the voice table, predicts each mixed sample, compares.
module pobk_mix_checker
    import pobk_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VOL_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [1:0]           i_op,
    input  logic [VOICE_W-1:0]   i_voice,
    input  logic [STEP_W-1:0]    i_phase_step,
    input  logic [VEL_W-1:0]     i_velocity,
    input  logic [STEP_W-1:0]    i_start_phase,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [SAMPLE_W-1:0]  i_sample,
    input  logic                 i_drain_done,
    output int                   o_fail_count,
    output int                   o_samples_due,
    output int                   o_samples_checked
);

    localparam int     NUM_VOICES      = 128;
    localparam longint VEL_FULL        = 127;
    localparam longint SAT_HI          = 64'sd2147483647;
    localparam longint SAT_LO          = -64'sd2147483648;

    // round(32767 * sin(pi * i / 128)), i = 0..64
    localparam int SINE_QUARTER [65] = '{
        0, 804, 1608, 2411, 3212, 4011, 4808, 5602,
        6393, 7179, 7962, 8739, 9512, 10278, 11039, 11793,
        12539, 13279, 14010, 14732, 15446, 16151, 16846, 17530,
        18204, 18868, 19519, 20159, 20787, 21403, 22005, 22594,
        23170, 23731, 24279, 24811, 25329, 25832, 26319, 26790,
        27245, 27683, 28105, 28510, 28898, 29268, 29621, 29956,
        30273, 30571, 30852, 31113, 31356, 31580, 31785, 31971,
        32137, 32285, 32412, 32521, 32609, 32678, 32728, 32757,
        32767
    };

    logic                       voice_on  [NUM_VOICES];
    logic [STEP_W-1:0]          osc_phase [NUM_VOICES];
    logic [STEP_W-1:0]          osc_step  [NUM_VOICES];
    logic [VEL_W-1:0]           osc_level [NUM_VOICES];
    logic [VOL_W-1:0]           gain;
    t_wave                      shape;
    logic signed [SAMPLE_W-1:0] samples_due [$];
    logic signed [SAMPLE_W-1:0] want;
    int                         fail_total    = 0;
    int                         checked_total = 0;
    logic                       drained;

    task automatic report_mismatch(input string what);
        fail_total++;
        $display("[%0t] mix check: %s", $time, what);
    endtask

    // Q1.15 wave value at the top 16 bits of a phase
    function automatic int wave_value(t_wave sel, logic [STEP_W-1:0] ph);
        logic [15:0] f;
        int          ix;
        int          v;
        f  = ph[STEP_W-1 -: 16];
        ix = int'(f[13:8]);
        case (sel)
            WF_SINE: begin
                v = f[14] ? SINE_QUARTER[64 - ix] : SINE_QUARTER[ix];
                if (f[15])
                    v = -v;
            end
            WF_TRIANGLE: begin
                if (f < 16'h4000)
                    v = 2 * int'(f);
                else if (f < 16'hC000)
                    v = 2 * (32768 - int'(f));
                else
                    v = 2 * (int'(f) - 65536);
            end
            WF_SAW: v = 32768 - int'(f);
            default: v = f[15] ? -32768 : 32767;
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v;
    endfunction

    // Sum every active voice, then step all active phases (wrap at the phase width), then saturate the sum
    function automatic logic signed [SAMPLE_W-1:0] mix_and_advance();
        longint sum;
        longint term;
        sum = 0;
        for (int k = 0; k < NUM_VOICES; k++) begin
            if (voice_on[k]) begin
                term = longint'(gain) * longint'(osc_level[k])
                       * longint'(wave_value(shape, osc_phase[k]));
                sum += term / VEL_FULL;
            end
        end
        for (int k = 0; k < NUM_VOICES; k++) begin
            if (voice_on[k])
                osc_phase[k] = osc_phase[k] + osc_step[k];
        end
        if (sum > SAT_HI)
            sum = SAT_HI;
        if (sum < SAT_LO)
            sum = SAT_LO;
        return SAMPLE_W'(sum);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_VOICES; k++)
                voice_on[k] = 1'b0;
            gain  = VOLUME_RESET;
            shape = WF_SINE;
            samples_due.delete();
            drained = 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_VOLUME)
                    gain = i_cfg_data;
                else if (i_cfg_idx == CFG_WAVEFORM)
                    shape = t_wave'(i_cfg_data[1:0]);
            end
            // compare outgoing samples first: the front is always older than this edge
            if (i_out_valid && !i_out_stall) begin
                checked_total++;
                if (samples_due.size() == 0) begin
                    report_mismatch($sformatf("sample %0d with no tick waiting",
                                              $signed(i_sample)));
                end else begin
                    want = samples_due.pop_front();
                    if (i_sample !== want)
                        report_mismatch($sformatf("sample %0d, expected %0d",
                                                  $signed(i_sample), want));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (t_op'(i_op) == OP_TICK) begin
                    samples_due.push_back(mix_and_advance());
                end else if (int'(i_voice) < NUM_VOICES) begin
                    case (t_op'(i_op))
                        OP_START: begin
                            voice_on[i_voice]  = 1'b1;
                            osc_step[i_voice]  = i_phase_step;
                            osc_level[i_voice] = i_velocity;
                            osc_phase[i_voice] = i_start_phase;
                        end
                        OP_CHANGE: begin
                            if (voice_on[i_voice]) begin
                                osc_step[i_voice]  = i_phase_step;
                                osc_level[i_voice] = i_velocity;
                            end
                        end
                        default: voice_on[i_voice] = 1'b0;
                    endcase
                end
            end
            if (i_drain_done && !drained) begin
                drained = 1'b1;
                if (samples_due.size() != 0)
                    report_mismatch($sformatf("%0d samples never came out",
                                              samples_due.size()));
            end
        end
        o_fail_count      <= fail_total;
        o_samples_due     <= samples_due.size();
        o_samples_checked <= checked_total;
    end

endmodule

>>> test/tb_polyphonic_oscillator_bank_core.sv
// Testbench top for the oscillator bank core: note events, ticks, register writes and verdict.
module tb_polyphonic_oscillator_bank_core;
    import pobk_pkg::*;

    localparam int CLK_HALF         = 6;
    localparam int RESET_CYCLES     = 6;
    localparam int MAX_WAIT         = 8;
    // room after the last sample so that queued note events can finish as well
    localparam int SETTLE_CYCLES    = 170;
    localparam int RUN_LIMIT_CYCLES = 600000;
    localparam int RANDOM_PHASES    = 6;
    localparam int ITEMS_PER_PHASE  = 130;
    // register indexes with nothing behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [VOL_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    t_op                  in_op;
    logic [VOICE_W-1:0]   in_voice;
    logic [STEP_W-1:0]    in_step;
    logic [VEL_W-1:0]     in_vel;
    logic [STEP_W-1:0]    in_start;
    logic                 out_valid;
    logic                 out_stall;
    logic [SAMPLE_W-1:0]  out_sample;
    logic                 drain_done;

    int fail_count;
    int samples_due;
    int samples_checked;

    // steady: no gaps on either side, to pack transfers back to back
    bit steady = 1'b0;
    int op_count [4] = '{0, 0, 0, 0};
    int settings_used = 0;

    polyphonic_oscillator_bank_core i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_op          (in_op),
        .i_voice       (in_voice),
        .i_phase_step  (in_step),
        .i_velocity    (in_vel),
        .i_start_phase (in_start),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_sample      (out_sample)
    );

    pobk_mix_checker u_mix_check (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_op              (in_op),
        .i_voice           (in_voice),
        .i_phase_step      (in_step),
        .i_velocity        (in_vel),
        .i_start_phase     (in_start),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_sample          (out_sample),
        .i_drain_done      (drain_done),
        .o_fail_count      (fail_count),
        .o_samples_due     (samples_due),
        .o_samples_checked (samples_checked)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Hard stop: covers a hung handshake or a sample that never shows up
    initial begin
        #(RUN_LIMIT_CYCLES * 2 * CLK_HALF);
        $display("Regression FAIL");
        $finish;
    end

    // Sample sink: after each transfer, hold stall high for a random number of cycles
    initial begin : sample_sink
        int hold;
        hold = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall) begin
                hold = steady ? 0 : $urandom_range(0, MAX_WAIT);
                out_stall <= (hold != 0);
            end else if (hold > 0) begin
                hold--;
                if (hold == 0)
                    out_stall <= 1'b0;
            end
        end
    end

    // Present one item after a random gap and hold it until its transfer.
    // Call and return right after a rising edge.
    task automatic send_item(input t_op op, input logic [VOICE_W-1:0] voice,
                             input logic [STEP_W-1:0] step, input logic [VEL_W-1:0] vel,
                             input logic [STEP_W-1:0] start);
        int gap;
        gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_voice <= voice;
        in_step  <= step;
        in_vel   <= vel;
        in_start <= start;
        do @(posedge clk); while (in_stall);
        op_count[op]++;
    endtask

    // Drop valid, wait for every pending sample, then let the engine settle
    task automatic drain_results(input int settle);
        in_valid <= 1'b0;
        do @(posedge clk); while (samples_due != 0);
        repeat (settle) @(posedge clk);
    endtask

    // Write both registers back to back; junk upper bits ride along on the waveform write
    task automatic program_regs(input logic [VOL_W-1:0] gain, input t_wave shape,
                                input bit spare);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_VOLUME;
        cfg_data <= gain;
        @(posedge clk);
        cfg_idx  <= CFG_WAVEFORM;
        cfg_data <= {14'($urandom), shape};
        @(posedge clk);
        if (spare) begin
            // writes to unused indexes must leave both registers alone
            cfg_idx  <= CFG_SPARE_A;
            cfg_data <= 16'($urandom);
            @(posedge clk);
            cfg_idx  <= CFG_SPARE_B;
            cfg_data <= 16'($urandom);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin : stimulus
        int                 r;
        t_op                rop;
        logic [VOICE_W-1:0] rvoice;
        logic [STEP_W-1:0]  rstep;
        logic [VOL_W-1:0]   gsel;
        t_wave              wsel;
        bit                 spare;

        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_idx    <= CFG_VOLUME;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        in_op      <= OP_TICK;
        in_voice   <= '0;
        in_step    <= '0;
        in_vel     <= '0;
        in_start   <= '0;
        drain_done <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at reset settings (unity gain, sine)
        send_item(OP_TICK,   7'd0,   24'd0,       7'd0,   24'd0);        // silent bank
        send_item(OP_START,  7'd0,   24'd0,       7'd127, 24'd0);
        send_item(OP_START,  7'd127, 24'hFFFFFF,  7'd127, 24'hFFFFFF);
        send_item(OP_START,  7'd64,  24'h555555,  7'd0,   24'h400000);   // zero velocity
        send_item(OP_CHANGE, 7'd5,   24'h0ABCDE,  7'd99,  24'd0);        // idle voice: drop
        send_item(OP_STOP,   7'd6,   24'd0,       7'd0,   24'd0);        // idle voice: drop
        send_item(OP_TICK,   7'd0,   24'd0,       7'd0,   24'd0);
        send_item(OP_START,  7'd0,   24'h123456,  7'd64,  24'h800000);   // restart a live voice
        send_item(OP_CHANGE, 7'd127, 24'd1,       7'd1,   24'hFFFFFF);
        send_item(OP_TICK,   7'd0,   24'd0,       7'd0,   24'd0);
        send_item(OP_TICK,   7'h7F,  24'hFFFFFF,  7'h7F,  24'hFFFFFF);
        send_item(OP_STOP,   7'd0,   24'd0,       7'd0,   24'd0);
        send_item(OP_STOP,   7'd127, 24'd0,       7'd0,   24'd0);
        send_item(OP_STOP,   7'd64,  24'd0,       7'd0,   24'd0);
        send_item(OP_TICK,   7'd0,   24'd0,       7'd0,   24'd0);

        // Two full-scale square voices at full gain: clip high, then clip low
        drain_results(SETTLE_CYCLES);
        program_regs(16'hFFFF, WF_SQUARE, 1'b0);
        send_item(OP_START,  7'd10,  24'h800000,  7'd127, 24'd0);
        send_item(OP_START,  7'd11,  24'h800000,  7'd127, 24'h3FFFFF);
        send_item(OP_TICK,   7'd0,   24'd0,       7'd0,   24'd0);
        send_item(OP_TICK,   7'd0,   24'd0,       7'd0,   24'd0);
        send_item(OP_STOP,   7'd10,  24'd0,       7'd0,   24'd0);
        send_item(OP_STOP,   7'd11,  24'd0,       7'd0,   24'd0);

        // Random part: one register setting per phase, gain and shape extremes included
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_results(SETTLE_CYCLES);
            spare = 1'b0;
            case (ph)
                0: begin
                    gsel = VOLUME_RESET;
                    wsel = WF_SINE;
                end
                1: begin
                    gsel = '0;
                    wsel = WF_TRIANGLE;
                end
                2: begin
                    gsel = 16'($urandom);
                    wsel = WF_SAW;
                end
                3: begin
                    gsel = 16'hFFFF;
                    wsel = WF_SQUARE;
                end
                4: begin
                    gsel  = 16'($urandom);
                    wsel  = WF_SINE;
                    spare = 1'b1;
                end
                default: begin
                    gsel = 16'($urandom);
                    wsel = t_wave'(2'($urandom));
                end
            endcase
            program_regs(gsel, wsel, spare);
            steady = (ph == 2 || ph == 5);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    rop = OP_TICK;
                else if (r < 65)
                    rop = OP_START;
                else if (r < 80)
                    rop = OP_CHANGE;
                else
                    rop = OP_STOP;
                // mostly a small pool so changes and stops hit live voices
                rvoice = ($urandom_range(0, 3) == 0) ? 7'($urandom)
                                                     : 7'($urandom_range(0, 11));
                rstep  = $urandom_range(0, 1) ? 24'($urandom)
                                              : 24'($urandom_range(0, 65535));
                send_item(rop, rvoice, rstep, 7'($urandom), 24'($urandom));
                // now and then hold off until the bank has caught up
                if ($urandom_range(0, 59) == 0)
                    drain_results(0);
            end
        end

        drain_results(SETTLE_CYCLES);
        drain_done <= 1'b1;
        repeat (2) @(posedge clk);

        $display("Covered %0d note starts, %0d changes, %0d stops, %0d ticks over %0d settings.",
                 op_count[OP_START], op_count[OP_CHANGE], op_count[OP_STOP],
                 op_count[OP_TICK], settings_used);
        $display("Compared %0d mixed samples; %0d mismatches.", samples_checked, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
